// ----- rtl/core/rbch_pkg.sv -----
// Shared widths and types for the ray/box closest-hit block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbch_pkg;

    localparam int COORD_BITS    = 32;             // Q16.16 coordinates
    localparam int ENTITY_BITS   = 16;
    localparam int DIST_BITS     = 31;             // unsigned Q15.16 distance
    localparam int UNIT_SHIFT    = 30;             // Q2.30 unit direction
    localparam int MAG_BITS      = COORD_BITS + 1; // magnitude of a coordinate difference
    localparam int DIVIDEND_BITS = MAG_BITS + UNIT_SHIFT;
    localparam int DIVISOR_BITS  = 32;
    localparam int SUM_BITS      = 2 * COORD_BITS;
    localparam int ROOT_BITS     = SUM_BITS / 2;
    localparam int T_BITS        = 64;             // signed slab distance

    localparam logic CMD_RAY = 1'b0;
    localparam logic CMD_BOX = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [T_BITS-1:0]     t_dist;

endpackage

// ----- rtl/core/rbch_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rbch_pkg for operand widths.
`timescale 1ns / 1ps

module rbch_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rbch_pkg::DIVIDEND_BITS-1:0] i_dividend,
    input  logic [rbch_pkg::DIVISOR_BITS-1:0]  i_divisor,
    output logic                              o_done,
    output logic [rbch_pkg::DIVIDEND_BITS-1:0] o_quotient
);
    import rbch_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_den;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS:0]    w_trial;
    logic                     w_ge;

    // Shift the next dividend bit into the partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIVIDEND_BITS - 1);
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIVISOR_BITS'(w_trial - {1'b0, r_den})
                              : w_trial[DIVISOR_BITS-1:0];
                r_quo <= {r_quo[DIVIDEND_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/rbch_sqrt.sv -----
// Iterative integer square root, one root bit per cycle.
// Depends on rbch_pkg for operand widths.
`timescale 1ns / 1ps

module rbch_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rbch_pkg::SUM_BITS-1:0]  i_radicand,
    output logic                          o_done,
    output logic [rbch_pkg::ROOT_BITS-1:0] o_root
);
    import rbch_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS);
    localparam int REM_BITS = ROOT_BITS + 2;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [SUM_BITS-1:0]   r_rad;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;
    logic [REM_BITS+1:0]   w_cur;
    logic [REM_BITS+1:0]   w_trial;
    logic                  w_ge;

    // Bring down the next bit pair and try root*4+1
    always_comb begin
        w_cur   = {r_rem, r_rad[SUM_BITS-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (w_cur >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ROOT_BITS - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[SUM_BITS-3:0], 2'b00};
                r_rem  <= w_ge ? REM_BITS'(w_cur - w_trial) : REM_BITS'(w_cur);
                r_root <= {r_root[ROOT_BITS-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/core/ray_box_closest_hit_top.sv -----
// Ray versus axis-aligned box closest-hit unit: sequencer, multiplier, result register.
// Depends on rbch_pkg, rbch_div and rbch_sqrt.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_ready): a ray beat (cmd 0) loads origin, direction and
//   limit; box beats (cmd 1) follow, each tested against the stored ray. The beat
//   with i_last_item set closes the query and produces exactly one result beat.
//   Output channel (o_valid / i_ready): hit flag, distance, hit point and entity.
//   A miss, a zero direction or boxes with no ray give an all-zero result.
//   Timing: one beat at a time; o_ready is low while a beat is being worked on.
//   A ray beat runs three squares on the shared multiplier, a 32-step square
//   root and three 63-step divides on the shared divider. A box beat runs two
//   63-step divides per axis that is not parallel, fewer when an axis misses
//   early. The result forms the hit point with three products on the multiplier.
//   The result waits in its output register; a stall on i_ready holds only the
//   beat that ends a query. Reset clears the stored ray and any pending result.
module ray_box_closest_hit_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_ax,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_ay,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_az,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_bx,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_by,
    input  logic signed [rbch_pkg::COORD_BITS-1:0] i_coord_bz,
    input  logic [rbch_pkg::DIST_BITS-1:0]      i_max_distance,
    input  logic [rbch_pkg::ENTITY_BITS-1:0]    i_entity_id,
    input  logic                                i_last_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [rbch_pkg::DIST_BITS-1:0]      o_hit_distance,
    output logic signed [rbch_pkg::COORD_BITS-1:0] o_hit_x,
    output logic signed [rbch_pkg::COORD_BITS-1:0] o_hit_y,
    output logic signed [rbch_pkg::COORD_BITS-1:0] o_hit_z,
    output logic [rbch_pkg::ENTITY_BITS-1:0]    o_hit_entity
);
    import rbch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_MUL, S_SQ_ACC, S_LEN, S_SQRT, S_NORM, S_NORM_WAIT,
        S_AXIS, S_DIV_A, S_DIV_B, S_SLAB, S_CHECK, S_BEST, S_EMIT,
        S_HIT_MUL, S_HIT_ADD
    } t_state;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    t_state                r_state;
    logic [1:0]            r_axis;
    t_coord                r_org  [3];
    t_coord                r_dir  [3];
    t_coord                r_unit [3];
    t_coord                r_bmin [3];
    t_coord                r_bmax [3];
    t_coord                r_hitp [3];
    logic [DIST_BITS-1:0]  r_limit;
    logic [DIST_BITS-1:0]  r_best;
    logic [ENTITY_BITS-1:0] r_best_ent;
    logic [ENTITY_BITS-1:0] r_ent;
    logic                  r_ray_valid;
    logic                  r_found;
    logic                  r_last;
    logic                  r_neg;
    logic                  r_out_pend;
    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   r_prod;
    logic [ROOT_BITS-1:0]  r_len;
    t_dist                 r_ta;
    t_dist                 r_tb;
    t_dist                 r_t0;
    t_dist                 r_t1;

    logic                  r_out_valid;
    logic                  r_o_hit;
    logic [DIST_BITS-1:0]  r_o_dist;
    t_coord                r_o_x;
    t_coord                r_o_y;
    t_coord                r_o_z;
    logic [ENTITY_BITS-1:0] r_o_ent;

    logic                  w_in_beat;
    logic                  w_out_free;
    t_coord                w_org;
    t_coord                w_unit;
    t_coord                w_dir;
    t_coord                w_bound;
    logic signed [MAG_BITS-1:0] w_diff;
    logic [MAG_BITS-1:0]   w_diff_mag;
    logic [MAG_BITS-1:0]   w_dir_mag;
    logic [COORD_BITS-1:0] w_unit_mag;
    logic [COORD_BITS-1:0] w_mul_a;
    logic [COORD_BITS-1:0] w_mul_b;
    logic                  w_div_start;
    logic [DIVIDEND_BITS-1:0] w_div_dividend;
    logic [DIVISOR_BITS-1:0]  w_div_divisor;
    logic                  w_div_done;
    logic [DIVIDEND_BITS-1:0] w_quo;
    t_dist                 w_quo_signed;
    logic                  w_sqrt_start;
    logic                  w_sqrt_done;
    logic [ROOT_BITS-1:0]  w_root;
    t_dist                 w_lo;
    t_dist                 w_hi;
    logic [COORD_BITS-1:0] w_off;
    logic signed [COORD_BITS+1:0] w_pt;
    t_coord                w_pt_sat;
    logic                  w_outside;
    t_state                w_fin;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // Select the operands of the current axis
    always_comb begin
        w_org      = r_org[r_axis];
        w_unit     = r_unit[r_axis];
        w_dir      = r_dir[r_axis];
        w_bound    = (r_state == S_AXIS) ? r_bmin[r_axis] : r_bmax[r_axis];
        w_diff     = MAG_BITS'(w_bound) - MAG_BITS'(w_org);
        w_diff_mag = w_diff[MAG_BITS-1] ? MAG_BITS'(-w_diff) : MAG_BITS'(w_diff);
        w_dir_mag  = w_dir[COORD_BITS-1] ? MAG_BITS'(-MAG_BITS'(w_dir))
                                         : MAG_BITS'(w_dir);
        w_unit_mag = w_unit[COORD_BITS-1] ? COORD_BITS'(-w_unit) : COORD_BITS'(w_unit);
        w_outside  = (w_org < r_bmin[r_axis]) || (w_org > r_bmax[r_axis]);
    end

    // Drive the shared multiplier: squares on a ray, offsets on a result
    always_comb begin
        if (r_state == S_HIT_MUL) begin
            w_mul_a = w_unit_mag;
            w_mul_b = COORD_BITS'(r_best);
        end else begin
            w_mul_a = w_dir_mag[COORD_BITS-1:0];
            w_mul_b = w_dir_mag[COORD_BITS-1:0];
        end
    end

    // Drive the shared divider
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = {w_diff_mag, {UNIT_SHIFT{1'b0}}};
        w_div_divisor  = DIVISOR_BITS'(w_unit_mag);
        unique case (r_state)
            S_NORM: begin
                w_div_start    = 1'b1;
                w_div_dividend = {w_dir_mag, {UNIT_SHIFT{1'b0}}};
                w_div_divisor  = r_len;
            end
            S_AXIS:  w_div_start = (w_unit != '0);
            S_DIV_A: w_div_start = w_div_done;
            default: w_div_start = 1'b0;
        endcase
    end

    assign w_sqrt_start = (r_state == S_LEN) && (r_sum != '0);
    assign w_quo_signed = r_neg ? -T_BITS'(w_quo) : T_BITS'(w_quo);

    // Slab update and hit-point arithmetic
    always_comb begin
        w_lo     = (r_ta > r_tb) ? r_tb : r_ta;
        w_hi     = (r_ta > r_tb) ? r_ta : r_tb;
        w_off    = r_prod[UNIT_SHIFT +: COORD_BITS];
        w_pt     = w_unit[COORD_BITS-1] ? (COORD_BITS+2)'(w_org) - (COORD_BITS+2)'(w_off)
                                        : (COORD_BITS+2)'(w_org) + (COORD_BITS+2)'(w_off);
        if (w_pt[COORD_BITS+1:COORD_BITS-1] == 3'b000 ||
            w_pt[COORD_BITS+1:COORD_BITS-1] == 3'b111) begin
            w_pt_sat = w_pt[COORD_BITS-1:0];
        end else begin
            w_pt_sat = w_pt[COORD_BITS+1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                          : {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        w_fin = r_last ? S_EMIT : S_IDLE;
    end

    rbch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    rbch_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_sum),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Multiplier output register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Sequencer, stored ray and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_ray_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_org[k]  <= '0;
                r_unit[k] <= '0;
            end
            r_limit    <= '0;
            r_best     <= '0;
            r_best_ent <= '0;
        end else begin
            // drop the result beat once taken, unless the next one replaces it
            if (r_out_valid && i_ready && !r_out_pend) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_last <= i_last_item;
                        r_axis <= '0;
                        if (i_cmd == CMD_RAY) begin
                            r_org[0]   <= i_coord_ax;
                            r_org[1]   <= i_coord_ay;
                            r_org[2]   <= i_coord_az;
                            r_dir[0]   <= i_coord_bx;
                            r_dir[1]   <= i_coord_by;
                            r_dir[2]   <= i_coord_bz;
                            r_limit    <= i_max_distance;
                            r_best     <= i_max_distance;
                            r_best_ent <= '0;
                            r_found    <= 1'b0;
                            r_ray_valid <= 1'b0;
                            for (int k = 0; k < 3; k++) begin
                                r_unit[k] <= '0;
                            end
                            r_sum   <= '0;
                            r_state <= i_last_item ? S_EMIT : S_SQ_MUL;
                        end else begin
                            r_bmin[0] <= i_coord_ax;
                            r_bmin[1] <= i_coord_ay;
                            r_bmin[2] <= i_coord_az;
                            r_bmax[0] <= i_coord_bx;
                            r_bmax[1] <= i_coord_by;
                            r_bmax[2] <= i_coord_bz;
                            r_ent     <= i_entity_id;
                            r_t0      <= '0;
                            r_t1      <= T_BITS'(r_limit);
                            if (r_ray_valid) begin
                                r_state <= S_AXIS;
                            end else begin
                                r_state <= i_last_item ? S_EMIT : S_IDLE;
                            end
                        end
                    end
                end
                // accumulate the squared direction
                S_SQ_MUL: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_sum <= r_sum + r_prod;
                    if (r_axis == LAST_AXIS) begin
                        r_axis  <= '0;
                        r_state <= S_LEN;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_LEN: r_state <= (r_sum == '0) ? S_IDLE : S_SQRT;
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_len   <= w_root;
                        r_state <= S_NORM;
                    end
                end
                // normalize one component per divide
                S_NORM: begin
                    r_neg   <= w_dir[COORD_BITS-1];
                    r_state <= S_NORM_WAIT;
                end
                S_NORM_WAIT: begin
                    if (w_div_done) begin
                        r_unit[r_axis] <= w_quo_signed[COORD_BITS-1:0];
                        if (r_axis == LAST_AXIS) begin
                            r_ray_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_NORM;
                        end
                    end
                end
                // slab test, one axis at a time
                S_AXIS: begin
                    r_neg <= w_diff[MAG_BITS-1] ^ w_unit[COORD_BITS-1];
                    if (w_unit != '0) begin
                        r_state <= S_DIV_A;
                    end else if (w_outside) begin
                        r_state <= w_fin;
                    end else if (r_axis == LAST_AXIS) begin
                        r_state <= S_BEST;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_DIV_A: begin
                    if (w_div_done) begin
                        r_ta    <= w_quo_signed;
                        r_neg   <= w_diff[MAG_BITS-1] ^ w_unit[COORD_BITS-1];
                        r_state <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (w_div_done) begin
                        r_tb    <= w_quo_signed;
                        r_state <= S_SLAB;
                    end
                end
                S_SLAB: begin
                    if (w_lo > r_t0) r_t0 <= w_lo;
                    if (w_hi < r_t1) r_t1 <= w_hi;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_t0 > r_t1) begin
                        r_state <= w_fin;
                    end else if (r_axis == LAST_AXIS) begin
                        r_state <= S_BEST;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_AXIS;
                    end
                end
                S_BEST: begin
                    if (r_t0 < T_BITS'(r_best)) begin
                        r_best     <= r_t0[DIST_BITS-1:0];
                        r_best_ent <= r_ent;
                        r_found    <= 1'b1;
                    end
                    r_state <= w_fin;
                end
                // build the hit point, then hand the result over
                S_EMIT: begin
                    r_axis <= '0;
                    if (r_ray_valid && r_found) begin
                        r_state <= S_HIT_MUL;
                    end else begin
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_HIT_MUL: r_state <= S_HIT_ADD;
                S_HIT_ADD: begin
                    r_hitp[r_axis] <= w_pt_sat;
                    if (r_axis == LAST_AXIS) begin
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_HIT_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // load the result register when it is free
            if (r_out_pend && w_out_free) begin
                r_out_pend  <= 1'b0;
                r_out_valid <= 1'b1;
                r_ray_valid <= 1'b0;
                r_found     <= 1'b0;
                if (r_ray_valid && r_found) begin
                    r_o_hit  <= 1'b1;
                    r_o_dist <= r_best;
                    r_o_x    <= r_hitp[0];
                    r_o_y    <= r_hitp[1];
                    r_o_z    <= r_hitp[2];
                    r_o_ent  <= r_best_ent;
                end else begin
                    r_o_hit  <= 1'b0;
                    r_o_dist <= '0;
                    r_o_x    <= '0;
                    r_o_y    <= '0;
                    r_o_z    <= '0;
                    r_o_ent  <= '0;
                end
            end
        end
    end

    assign o_ready        = (r_state == S_IDLE) && !r_out_pend;
    assign o_valid        = r_out_valid;
    assign o_hit          = r_o_hit;
    assign o_hit_distance = r_o_dist;
    assign o_hit_x        = r_o_x;
    assign o_hit_y        = r_o_y;
    assign o_hit_z        = r_o_z;
    assign o_hit_entity   = r_o_ent;

    // A stored hit always belongs to a valid ray
    a_found_needs_ray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_ray_valid)
        else $error("hit recorded without a valid ray");

    // A miss result carries no distance and no entity
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_hit) |-> (r_o_dist == '0 && r_o_ent == '0))
        else $error("miss result with nonzero payload");

    // Divider completions land only in the states that wait for them
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_NORM_WAIT || r_state == S_DIV_A ||
                        r_state == S_DIV_B))
        else $error("divider finished outside a divide wait");

    // Found hit never exceeds the ray limit
    a_best_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best <= r_limit))
        else $error("best distance beyond ray limit");

endmodule
